/* src/cpd_pkg.sv */
// Shared types and constants of the constant-over-pixel divider.
package cpd_pkg;

    // Field widths of the stream items.
    localparam int PIX_W      = 16;
    localparam int BAND_W     = 2;
    localparam int DIVIDEND_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 1;

    // Configuration port.
    localparam int REG_COUNT  = 4;
    localparam int REG_IDX_W  = 2;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Default number of bands that hold a constant.
    localparam int NUM_BANDS_DEFAULT = 4;

    // Divider pipeline: quotient bits resolved per stage and stage count.
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DIVIDEND_W / BITS_PER_STAGE;

    // Saturation limits of the signed 16-bit quotient.
    localparam logic [PIX_W-1:0] Q_MAX  = 16'h7FFF;
    localparam logic [PIX_W-1:0] Q_MIN  = 16'h8000;
    localparam logic [PIX_W-1:0] Q_ZERO = 16'h0000;

    // Magnitude limits used by the saturation compare.
    localparam logic [DIVIDEND_W-1:0] MAG_POS_MAX = 32'd32767;
    localparam logic [DIVIDEND_W-1:0] MAG_NEG_MAX = 32'd32768;

    // Payload carried from stage to stage of the divider.
    typedef struct packed {
        logic [PIX_W-1:0]      rem;       // partial remainder
        logic [DIVIDEND_W-1:0] dq;        // dividend bits out the top, quotient bits in below
        logic [PIX_W-1:0]      divisor;   // divisor magnitude
        logic                  neg_q;     // quotient is negative
        logic                  div_zero;  // pixel was zero
        logic                  c_neg;     // constant was negative
        logic                  c_zero;    // constant was zero
    } cpd_stage_t;

endpackage

/* src/cpd_regs.sv */
// Band constant registers behind the APB-style configuration port.
module cpd_regs #(
    parameter int NUM_BANDS = cpd_pkg::NUM_BANDS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cpd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cpd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic [cpd_pkg::BAND_W-1:0]          band_index,
    output logic [cpd_pkg::DIVIDEND_W-1:0]      band_const
);

    // Only bands that exist get a register; the others read as zero.
    localparam int NumRegs = (NUM_BANDS < cpd_pkg::REG_COUNT) ? NUM_BANDS : cpd_pkg::REG_COUNT;

    logic [cpd_pkg::DIVIDEND_W-1:0] band_reg [NumRegs];
    logic [cpd_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cpd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumRegs; i++) begin
                band_reg[i] <= '0;
            end
        end else if (wr_en) begin
            for (int i = 0; i < NumRegs; i++) begin
                if (reg_idx == cpd_pkg::REG_IDX_W'(i)) begin
                    band_reg[i] <= pwdata;
                end
            end
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        for (int i = 0; i < NumRegs; i++) begin
            if (reg_idx == cpd_pkg::REG_IDX_W'(i)) begin
                prdata = band_reg[i];
            end
        end
    end

    // Constant lookup for the incoming pixel's band.
    always_comb begin
        band_const = '0;
        for (int i = 0; i < NumRegs; i++) begin
            if (band_index == cpd_pkg::BAND_W'(i)) begin
                band_const = band_reg[i];
            end
        end
    end

endmodule

/* src/cpd_div_stage.sv */
// One registered stage of the restoring divider, resolving several quotient bits.
module cpd_div_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cpd_pkg::cpd_stage_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cpd_pkg::cpd_stage_t out_data
);

    logic                valid_reg;
    cpd_pkg::cpd_stage_t data_reg;
    cpd_pkg::cpd_stage_t data_next;

    // The stage takes new data when it is empty or its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift-subtract steps: each step brings down one dividend bit.
    always_comb begin
        logic [cpd_pkg::PIX_W:0] trial;
        data_next = in_data;
        for (int k = 0; k < cpd_pkg::BITS_PER_STAGE; k++) begin
            trial        = {data_next.rem, data_next.dq[cpd_pkg::DIVIDEND_W-1]};
            data_next.dq = {data_next.dq[cpd_pkg::DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, data_next.divisor}) begin
                data_next.rem   = cpd_pkg::PIX_W'(trial - {1'b0, data_next.divisor});
                data_next.dq[0] = 1'b1;
            end else begin
                data_next.rem = trial[cpd_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

/* src/const_over_pixel_divider_core.sv */
// Top level of the constant-over-pixel divider: input stage, divider pipeline, output stage.
//
// Each transaction on the s_ side carries a signed 16-bit pixel and its band number; the block
// divides that band's signed 32-bit constant by the pixel, truncates toward zero, saturates to
// the signed 16-bit range and returns one m_ transaction per input, in order. A zero pixel
// yields 0, -32768 or 32767 according to the sign of the constant and sets m_tuser. One pixel
// is accepted per clock cycle unless a stall on m_tready fills the pipeline. An input stage
// fetches the constant and takes magnitudes, eight restoring-division stages each resolve
// four quotient bits, and an output stage restores the sign and saturates. Every stage has its
// own valid bit and takes new data whenever it is empty or its content moves on, so bubbles
// close up, a stall on m_tready loses nothing. The user writes band constants via the APB-style
// port only while the stream is idle, which is not enforced; bands >= NUM_BANDS read as zero.
module const_over_pixel_divider_core #(
    parameter int NUM_BANDS = cpd_pkg::NUM_BANDS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cpd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] pixel_value
    input  logic [cpd_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] band_index
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cpd_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] quotient
    output logic [cpd_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] divide_by_zero
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cpd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int NumPipe = cpd_pkg::DIV_STAGES + 2;
    localparam int CountW  = $clog2(NumPipe + 1);

    logic [cpd_pkg::DIVIDEND_W-1:0] band_const;
    logic [cpd_pkg::PIX_W-1:0]      pixel;
    logic                           pixel_neg;
    logic                           const_neg;

    logic                front_valid_reg;
    cpd_pkg::cpd_stage_t front_reg;
    cpd_pkg::cpd_stage_t front_next;
    logic                front_ready;

    logic                stage_valid [cpd_pkg::DIV_STAGES+1];
    logic                stage_ready [cpd_pkg::DIV_STAGES+1];
    cpd_pkg::cpd_stage_t stage_data  [cpd_pkg::DIV_STAGES+1];

    logic                         out_valid_reg;
    logic [cpd_pkg::PIX_W-1:0]    quotient_reg;
    logic [cpd_pkg::PIX_W-1:0]    quotient_next;
    logic                         div_zero_reg;
    logic                         back_ready;
    cpd_pkg::cpd_stage_t          back_in;

    logic [CountW-1:0]  inflight_reg;
    logic [NumPipe-1:0] occupancy;

    // Band constant registers.
    cpd_regs #(
        .NUM_BANDS (NUM_BANDS)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .band_index (s_tuser[cpd_pkg::BAND_W-1:0]),
        .band_const (band_const)
    );

    // Input stage: fetch the constant, split signs from magnitudes.
    assign pixel     = s_tdata[cpd_pkg::PIX_W-1:0];
    assign pixel_neg = pixel[cpd_pkg::PIX_W-1];
    assign const_neg = band_const[cpd_pkg::DIVIDEND_W-1];

    always_comb begin
        front_next.rem      = '0;
        front_next.dq       = const_neg ? (cpd_pkg::DIVIDEND_W'(0) - band_const) : band_const;
        front_next.divisor  = pixel_neg ? (cpd_pkg::PIX_W'(0) - pixel) : pixel;
        front_next.neg_q    = const_neg ^ pixel_neg;
        front_next.div_zero = (pixel == '0);
        front_next.c_neg    = const_neg;
        front_next.c_zero   = (band_const == '0);
    end

    assign front_ready = !front_valid_reg || stage_ready[0];
    assign s_tready    = front_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (front_ready) begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && front_ready) begin
            front_reg <= front_next;
        end
    end

    // Divider pipeline.
    assign stage_valid[0] = front_valid_reg;
    assign stage_data[0]  = front_reg;
    assign stage_ready[cpd_pkg::DIV_STAGES] = back_ready;

    for (genvar g = 0; g < cpd_pkg::DIV_STAGES; g++) begin : g_div
        cpd_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // Output stage: substitute on a zero pixel, else restore the sign and saturate.
    assign back_in    = stage_data[cpd_pkg::DIV_STAGES];
    assign back_ready = !out_valid_reg || m_tready;

    always_comb begin
        if (back_in.div_zero) begin
            if (back_in.c_zero) begin
                quotient_next = cpd_pkg::Q_ZERO;
            end else if (back_in.c_neg) begin
                quotient_next = cpd_pkg::Q_MIN;
            end else begin
                quotient_next = cpd_pkg::Q_MAX;
            end
        end else if (back_in.neg_q) begin
            if (back_in.dq > cpd_pkg::MAG_NEG_MAX) begin
                quotient_next = cpd_pkg::Q_MIN;
            end else begin
                quotient_next = cpd_pkg::PIX_W'(0) - back_in.dq[cpd_pkg::PIX_W-1:0];
            end
        end else begin
            if (back_in.dq > cpd_pkg::MAG_POS_MAX) begin
                quotient_next = cpd_pkg::Q_MAX;
            end else begin
                quotient_next = back_in.dq[cpd_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (back_ready) begin
            out_valid_reg <= stage_valid[cpd_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_valid[cpd_pkg::DIV_STAGES] && back_ready) begin
            quotient_reg <= quotient_next;
            div_zero_reg <= back_in.div_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = quotient_reg;
    assign m_tuser  = div_zero_reg;

    // Count of transactions accepted but not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            case ({s_tvalid && s_tready, m_tvalid && m_tready})
                2'b10:   inflight_reg <= inflight_reg + CountW'(1);
                2'b01:   inflight_reg <= inflight_reg - CountW'(1);
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    always_comb begin
        occupancy[0] = front_valid_reg;
        for (int i = 1; i <= cpd_pkg::DIV_STAGES; i++) begin
            occupancy[i] = stage_valid[i];
        end
        occupancy[NumPipe-1] = out_valid_reg;
    end

    // Every accepted transaction sits in exactly one stage until delivered.
    a_inflight_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == CountW'($countones(occupancy)))
        else $error("in-flight count does not match stage occupancy");

    // An empty output register lets the whole pipeline advance.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // A divide-by-zero result only ever carries one of the three substitutes.
    a_zero_substitute: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata == cpd_pkg::Q_ZERO || m_tdata == cpd_pkg::Q_MIN ||
             m_tdata == cpd_pkg::Q_MAX))
        else $error("divide-by-zero result is not a substitute value");

    // The pipeline never holds more transactions than it has stages.
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (inflight_reg < CountW'(NumPipe) || (m_tvalid && m_tready)))
        else $error("transaction accepted into a full pipeline");

endmodule
